// ===== hdl/nfsa_pkg.sv =====
// Shared types and constants for the next-fit slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package nfsa_pkg;

  // Built capacity and field widths
  localparam int MAX_SLOTS    = 256;
  localparam int SLOT_W       = 8;
  localparam int CNT_W        = 9;
  localparam int REC_W        = 16;
  localparam int OFS_W        = 24;
  localparam int HEADER_BYTES = 16;  // four 32-bit words ahead of the map

  // Request function codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_ADDR  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ALL_USED = 2'd1;
  localparam logic [1:0] STAT_NO_FREE  = 2'd2;
  localparam logic [1:0] STAT_RANGE    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLOT_COUNT   = 2'd0;
  localparam logic [1:0] CFG_RECORD_BYTES = 2'd1;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_SET,
    CELL_CLEAR,
    CELL_CLEAR_ALL
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [SLOT_W-1:0] idx;   // slot addressed by load, clear and lookup
    logic [SLOT_W-1:0] last;  // highest live slot, where the token wraps
    logic              wrap;  // token re-enters at slot 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/next_fit_slot_allocator_core.sv =====
// Top level of the next-fit slot allocator: controller and row of slot cells.
`timescale 1ns / 1ps
`default_nettype none

// Next-fit slot allocator for fixed-length records.
// Requests: in_func / in_slot_index are taken when start is high and busy low.
// Results: out_valid strobes for one cycle with status, granted slot, record
// offset and the used count after the request; the receiver cannot stall, and
// a new request may be taken in the same cycle a result is shown.
// Free, address query, clear and an allocate refused because every slot is
// counted used: result in the cycle after acceptance.
// Allocate that scans: a token walks the row of slot cells one cell per
// cycle from the last granted position, wrapping at the live slot count; the
// result comes once a free slot is found or every live slot has been
// visited (slot_count capped at 256). busy stays high during the scan.
// The record offset uses one 16x8 multiply in the acceptance cycle.
// Configuration: cfg_valid/cfg_ready write slot_count (index 0) or
// record_bytes (index 1); cfg_ready is always high, other indexes ignored.
// Reset (synchronous, rst_n low): every slot free, used count and last
// position zero, slot_count 256, record_bytes 1. Clear frees all slots at once.
module next_fit_slot_allocator_core
  import nfsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_func,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [SLOT_W-1:0]      out_granted_slot,
  output logic [OFS_W-1:0]       out_record_offset,
  output logic [CNT_W-1:0]       out_used_slots,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [REC_W-1:0]  cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  slot_count_r;
  logic [REC_W-1:0]  record_bytes_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] steps_r, steps_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [SLOT_W-1:0] granted_r, granted_nxt;
  logic [OFS_W-1:0]  offset_r, offset_nxt;
  logic [CNT_W-1:0]  used_out_r, used_out_nxt;

  cell_ctrl_t        ctrl;
  logic [MAX_SLOTS-1:0] tok_link;
  logic [MAX_SLOTS-1:0] hit_vec;
  logic [MAX_SLOTS-1:0] busy_vec;

  logic [CNT_W-1:0]  live_n;
  logic [CNT_W-1:0]  live_m1;
  logic              accept;
  logic              idx_ok;
  logic              found;
  logic              idx_busy;
  logic [SLOT_W-1:0] start_pos;
  logic              at_last;

  // Live slot count and derived limits
  assign live_n    = (slot_count_r > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_r;
  assign live_m1   = live_n - CNT_W'(1);
  assign accept    = start & (state_r == ST_IDLE);
  assign idx_ok    = ({1'b0, in_slot_index} < live_n);
  assign found     = |hit_vec;
  assign idx_busy  = |busy_vec;
  assign start_pos = ({1'b0, last_r} < live_n) ? last_r : '0;
  assign at_last   = (pos_r == live_m1[SLOT_W-1:0]);

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r   <= CNT_W'(MAX_SLOTS);
      record_bytes_r <= REC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLOT_COUNT:   slot_count_r   <= cfg_data[CNT_W-1:0];
        CFG_RECORD_BYTES: record_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request sequencing
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    granted_nxt   = '0;
    offset_nxt    = '0;
    used_out_nxt  = used_r;
    ctrl.op       = CELL_HOLD;
    ctrl.idx      = in_slot_index;
    ctrl.last     = live_m1[SLOT_W-1:0];
    ctrl.wrap     = 1'b0;

    priority if (state_r == ST_IDLE) begin
      if (accept) begin
        unique case (in_func)
          FUNC_ALLOC: begin
            if (used_r >= live_n) begin
              out_valid_nxt = 1'b1;
              status_nxt    = STAT_ALL_USED;
            end else begin
              ctrl.op   = CELL_LOAD;
              ctrl.idx  = start_pos;
              pos_nxt   = start_pos;
              steps_nxt = '0;
              state_nxt = ST_SCAN;
            end
          end
          FUNC_FREE: begin
            out_valid_nxt = 1'b1;
            if (!idx_ok) begin
              status_nxt = STAT_RANGE;
            end else if (idx_busy) begin
              ctrl.op      = CELL_CLEAR;
              used_nxt     = (used_r != '0) ? used_r - CNT_W'(1) : used_r;
              used_out_nxt = used_nxt;
            end
          end
          FUNC_ADDR: begin
            out_valid_nxt = 1'b1;
            if (!idx_ok) begin
              status_nxt = STAT_RANGE;
            end else begin
              offset_nxt = OFS_W'(HEADER_BYTES) + OFS_W'(live_n)
                         + OFS_W'(record_bytes_r) * OFS_W'(in_slot_index);
            end
          end
          FUNC_CLEAR: begin
            out_valid_nxt = 1'b1;
            ctrl.op       = CELL_CLEAR_ALL;
            used_nxt      = '0;
            last_nxt      = '0;
            used_out_nxt  = '0;
          end
        endcase
      end
    end else begin
      // Scan: token sits on slot pos_r
      ctrl.idx = pos_r;
      if (found) begin
        ctrl.op       = CELL_SET;
        used_nxt      = used_r + CNT_W'(1);
        last_nxt      = pos_r;
        out_valid_nxt = 1'b1;
        granted_nxt   = pos_r;
        used_out_nxt  = used_nxt;
        state_nxt     = ST_IDLE;
      end else if ({1'b0, steps_r} == live_m1) begin
        out_valid_nxt = 1'b1;
        status_nxt    = STAT_NO_FREE;
        state_nxt     = ST_IDLE;
      end else begin
        ctrl.op   = CELL_SHIFT;
        ctrl.wrap = at_last;
        pos_nxt   = at_last ? '0 : pos_r + SLOT_W'(1);
        steps_nxt = steps_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      last_r      <= '0;
      pos_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      last_r      <= last_nxt;
      pos_r       <= pos_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    offset_r   <= offset_nxt;
    used_out_r <= used_out_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_slot  = granted_r;
  assign out_record_offset = offset_r;
  assign out_used_slots    = used_out_r;

  // Row of slot cells; the end of the row folds back to the head
  genvar gi;
  generate
    for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
      logic tok_in_w;
      if (gi == 0) begin : g_head
        assign tok_in_w = ctrl.wrap | tok_link[MAX_SLOTS-1];
      end else begin : g_body
        assign tok_in_w = tok_link[gi-1];
      end
      nfsa_cell #(
        .IDX(gi)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .tok_in  (tok_in_w),
        .tok_out (tok_link[gi]),
        .hit     (hit_vec[gi]),
        .busy_at (busy_vec[gi])
      );
    end
  endgenerate

endmodule

`default_nettype wire

// ===== hdl/nfsa_cell.sv =====
// One slot cell: busy bit plus the scan token handed to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module nfsa_cell
  import nfsa_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       tok_in,
  output logic            tok_out,
  output logic            hit,
  output logic            busy_at
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);

  logic busy_r, busy_nxt;
  logic tok_r, tok_nxt;
  logic addressed;

  assign addressed = (ctrl.idx == MY_IDX);

  // Next state per broadcast operation
  always_comb begin
    busy_nxt = busy_r;
    tok_nxt  = tok_r;
    unique case (ctrl.op)
      CELL_HOLD: ;
      CELL_LOAD:  tok_nxt = addressed;
      CELL_SHIFT: tok_nxt = tok_in;
      CELL_SET: begin
        busy_nxt = busy_r | tok_r;
        tok_nxt  = 1'b0;
      end
      CELL_CLEAR: busy_nxt = busy_r & ~addressed;
      CELL_CLEAR_ALL: begin
        busy_nxt = 1'b0;
        tok_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // Token stops at the last live slot; the controller wraps it
  assign tok_out = tok_r & (MY_IDX != ctrl.last);
  assign hit     = tok_r & ~busy_r;
  assign busy_at = busy_r & addressed;

endmodule

`default_nettype wire
